>>> design/wcwm_pkg.sv
// ----------------------------------------------------------------------------
// wcwm_pkg
// Shared types and constants for the word concatenation window match unit.
// ----------------------------------------------------------------------------
package wcwm_pkg;

  localparam int WCWM_MAX_WORD_LEN = 8;
  localparam int WCWM_MAX_WORDS    = 16;
  localparam int WCWM_POS_WIDTH    = 16;
  localparam int WCWM_CLS_W        = 3;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_TEXT    = 2'd3;

  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_FULL  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] word_bytes;
    logic [7:0]  text_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] match_start;
  } out_item_t;

endpackage

>>> design/word_concatenation_window_match_unit.sv
// ----------------------------------------------------------------------------
// word_concatenation_window_match_unit
// Streams text bytes against a loaded multiset of equal-length words and
// reports every start position of a concatenation of all of them.
//
//   channel  direction  handshake         payload
//   in       input      in_valid/in_stall  in_item_t  (command, word, byte)
//   out      output     out_valid/out_stall out_item_t (kind, match_start)
//   cfg      input      cfg_we             word length, 4 bits
//
// One item at a time. A text byte that completes a known word passes S_LOOK
// and S_CHK, plus S_SHID, S_SHDEC and S_RE per word dropped from the window's
// left end and S_EMIT when a result is produced; an unknown word leaves after
// S_LOOK. The window count memory's single read port sets the shrink step.
// Reset is synchronous and needs no clearing pass. A stalled output holds its
// result; the next result waits for it.
// ----------------------------------------------------------------------------
module word_concatenation_window_match_unit import wcwm_pkg::*; #(
  parameter int MAX_WORDS = WCWM_MAX_WORDS,
  parameter int POS_WIDTH = WCWM_POS_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [3:0] cfg_data
);

  localparam int IDW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNTW  = $clog2(MAX_WORDS + 1);
  localparam int CAW   = WCWM_CLS_W + IDW;
  localparam int DEPTH = WCWM_MAX_WORD_LEN << IDW;
  localparam int PW1   = POS_WIDTH + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ADD   = 9'b000000010,
    S_INC   = 9'b000000100,
    S_LOOK  = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_SHID  = 9'b000100000,
    S_SHDEC = 9'b001000000,
    S_RE    = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t                  state;
  logic [3:0]              word_length;
  logic [3:0]              len_eff;
  logic [CNTW-1:0]         distinct;
  logic [CNTW-1:0]         total;
  logic [63:0]             recent;
  logic [PW1-1:0]          pos;
  logic [WCWM_CLS_W-1:0]   pmod;
  logic [3:0]              pmod_inc;
  logic [WCWM_CLS_W-1:0]   pmod_next;
  logic [WCWM_CLS_W-1:0]   cls;
  logic [IDW-1:0]          id_q;
  logic [IDW-1:0]          old_q;
  logic [63:0]             add_word;
  logic [63:0]             add_mask;
  logic [63:0]             text_word;
  logic [63:0]             cam_key;
  logic                    cam_hit;
  logic [IDW-1:0]          cam_id;
  logic                    res_kind;
  logic [15:0]             res_start;
  logic                    in_acc;
  logic                    restart;

  logic [DEPTH-1:0]        vld;
  logic [IDW-1:0]          head [WCWM_MAX_WORD_LEN];
  logic [CNTW-1:0]         fill [WCWM_MAX_WORD_LEN];
  logic [IDW-1:0]          head_c;
  logic [CNTW-1:0]         fill_c;
  logic [IDW-1:0]          head_wrap;
  logic [IDW:0]            slot_sum;
  logic [IDW-1:0]          slot;

  logic [CNTW-1:0]         cnt_mem [DEPTH];
  logic [CNTW-1:0]         cnt_rd;
  logic                    cnt_rdv;
  logic [CNTW-1:0]         cnt_eff;
  logic                    cnt_re;
  logic                    cnt_we;
  logic [CAW-1:0]          cnt_raddr;
  logic [CAW-1:0]          cnt_waddr;
  logic [CNTW-1:0]         cnt_wdata;

  logic [IDW-1:0]          ids_mem [DEPTH];
  logic [IDW-1:0]          ids_rd;
  logic                    ids_re;
  logic                    ids_we;

  logic [CNTW-1:0]         tgt_mem [MAX_WORDS];
  logic [CNTW-1:0]         tgt_rd;
  logic                    tgt_re;
  logic                    tgt_we;
  logic [IDW-1:0]          tgt_waddr;
  logic [CNTW-1:0]         tgt_wdata;

  logic                    shrink;
  logic                    append;
  logic [PW1-1:0]          start;
  logic [PW1-1:0]          back;
  logic [PW1-1:0]          diff;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign restart  = cfg_we || (in_acc && (in_data.command != CMD_TEXT));

  always_comb begin
    if (word_length == 4'd0) begin
      len_eff = 4'd1;
    end else if (word_length > 4'(WCWM_MAX_WORD_LEN)) begin
      len_eff = 4'(WCWM_MAX_WORD_LEN);
    end else begin
      len_eff = word_length;
    end
  end

  always_comb begin
    if (len_eff >= 4'd8) begin
      add_mask = '1;
    end else begin
      add_mask = (64'd1 << {len_eff, 3'b000}) - 64'd1;
    end
  end

  assign text_word = recent >> (7'd64 - {len_eff, 3'b000});
  assign cam_key   = (state == S_ADD) ? add_word : text_word;

  assign pmod_inc  = {1'b0, pmod} + 4'd1;
  assign pmod_next = (pmod_inc == len_eff) ? '0 : pmod_inc[WCWM_CLS_W-1:0];

  assign head_c    = head[cls];
  assign fill_c    = fill[cls];
  assign head_wrap = (head_c == IDW'(MAX_WORDS - 1)) ? '0 : head_c + IDW'(1);
  assign slot_sum  = (IDW + 1)'(head_c) + (IDW + 1)'(fill_c);
  assign slot      = (slot_sum >= (IDW + 1)'(MAX_WORDS)) ?
                     IDW'(slot_sum - (IDW + 1)'(MAX_WORDS)) : slot_sum[IDW-1:0];

  assign cnt_eff = cnt_rdv ? cnt_rd : '0;
  assign shrink  = (cnt_eff >= tgt_rd) && (fill_c != '0);
  assign append  = !shrink && (fill_c < CNTW'(MAX_WORDS));

  assign start = pos - PW1'(len_eff);
  assign back  = PW1'(fill_c * {{CNTW{1'b0}}, len_eff});
  assign diff  = (start >= back) ? start - back : '0;

  wcwm_word_cam #(
    .MAX_WORDS (MAX_WORDS)
  ) u_cam (
    .clk    (clk),
    .we     (state == S_ADD && !cam_hit),
    .waddr  (distinct[IDW-1:0]),
    .wdata  (add_word),
    .key    (cam_key),
    .used   (distinct),
    .hit    (cam_hit),
    .hit_id (cam_id)
  );

  // memory port control
  always_comb begin
    cnt_re    = ((state == S_LOOK) && cam_hit) || (state == S_SHID) || (state == S_RE);
    cnt_raddr = {cls, id_q};
    if (state == S_LOOK) begin
      cnt_raddr = {cls, cam_id};
    end else if (state == S_SHID) begin
      cnt_raddr = {cls, ids_rd};
    end
    cnt_we    = ((state == S_CHK) && append) || ((state == S_SHDEC) && (cnt_eff != '0));
    cnt_waddr = (state == S_SHDEC) ? {cls, old_q} : {cls, id_q};
    cnt_wdata = (state == S_SHDEC) ? cnt_eff - CNTW'(1) : cnt_eff + CNTW'(1);

    ids_re    = (state == S_CHK) && shrink;
    ids_we    = (state == S_CHK) && append;

    tgt_re    = ((state == S_ADD) || (state == S_LOOK)) && cam_hit;
    tgt_we    = ((state == S_ADD) && !cam_hit) || (state == S_INC);
    tgt_waddr = (state == S_INC) ? id_q : distinct[IDW-1:0];
    tgt_wdata = (state == S_INC) ? tgt_rd + CNTW'(1) : CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd  <= cnt_mem[cnt_raddr];
      cnt_rdv <= vld[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ids_we) begin
      ids_mem[{cls, slot}] <= id_q;
    end
    if (ids_re) begin
      ids_rd <= ids_mem[{cls, head_c}];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    if (tgt_re) begin
      tgt_rd <= tgt_mem[cam_id];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      word_length <= 4'd1;
      distinct    <= '0;
      total       <= '0;
      recent      <= '0;
      pos         <= '0;
      pmod        <= '0;
      vld         <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < WCWM_MAX_WORD_LEN; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        word_length <= cfg_data;
      end
      if (restart) begin
        recent <= '0;
        pos    <= '0;
        pmod   <= '0;
        vld    <= '0;
        for (int i = 0; i < WCWM_MAX_WORD_LEN; i++) begin
          head[i] <= '0;
          fill[i] <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_data.command)
              CMD_CLEAR: begin
                distinct <= '0;
                total    <= '0;
              end
              CMD_ADD: begin
                if (total >= CNTW'(MAX_WORDS)) begin
                  res_kind  <= KIND_FULL;
                  res_start <= '0;
                  state     <= S_EMIT;
                end else begin
                  add_word <= in_data.word_bytes & add_mask;
                  state    <= S_ADD;
                end
              end
              CMD_RESTART: begin
              end
              CMD_TEXT: begin
                if (!pos[POS_WIDTH]) begin
                  recent <= {in_data.text_byte, recent[63:8]};
                  pos    <= pos + PW1'(1);
                  pmod   <= pmod_next;
                  cls    <= pmod_next;
                  if ((pos + PW1'(1) >= PW1'(len_eff)) && (distinct != '0)) begin
                    state <= S_LOOK;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          total <= total + CNTW'(1);
          if (cam_hit) begin
            id_q  <= cam_id;
            state <= S_INC;
          end else begin
            distinct <= distinct + CNTW'(1);
            state    <= S_IDLE;
          end
        end
        S_INC: begin
          state <= S_IDLE;
        end
        S_LOOK: begin
          if (cam_hit) begin
            id_q  <= cam_id;
            state <= S_CHK;
          end else begin
            for (int i = 0; i < (1 << IDW); i++) begin
              vld[{cls, IDW'(i)}] <= 1'b0;
            end
            head[cls] <= '0;
            fill[cls] <= '0;
            state     <= S_IDLE;
          end
        end
        S_CHK: begin
          if (shrink) begin
            state <= S_SHID;
          end else if (!append) begin
            state <= S_IDLE;
          end else begin
            fill[cls]         <= fill_c + CNTW'(1);
            vld[{cls, id_q}]  <= 1'b1;
            if (fill_c + CNTW'(1) == total) begin
              res_kind  <= KIND_MATCH;
              res_start <= 16'(diff);
              state     <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SHID: begin
          old_q <= ids_rd;
          state <= S_SHDEC;
        end
        S_SHDEC: begin
          head[cls] <= head_wrap;
          fill[cls] <= fill_c - CNTW'(1);
          state     <= S_RE;
        end
        S_RE: begin
          state <= S_CHK;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.kind        <= res_kind;
            out_data.match_start <= res_start;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/wcwm_word_cam.sv
// ----------------------------------------------------------------------------
// wcwm_word_cam
// Table of distinct words with a parallel compare against one key.
// ----------------------------------------------------------------------------
module wcwm_word_cam import wcwm_pkg::*; #(
  parameter int MAX_WORDS = WCWM_MAX_WORDS
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] waddr,
  input  logic [63:0]                               wdata,
  input  logic [63:0]                               key,
  input  logic [$clog2(MAX_WORDS + 1)-1:0]          used,
  output logic                                      hit,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] hit_id
);

  localparam int IDW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNTW = $clog2(MAX_WORDS + 1);

  logic [63:0]          words [MAX_WORDS];
  logic [MAX_WORDS-1:0] match;

  always_ff @(posedge clk) begin
    if (we) begin
      words[waddr] <= wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      match[i] = (CNTW'(i) < used) && (words[i] == key);
    end
  end

  always_comb begin
    hit_id = '0;
    for (int i = MAX_WORDS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_id = IDW'(i);
      end
    end
  end

  assign hit = |match;

endmodule
